FILE: rtl/pox_pkg.sv
// Package for the permutation order crossover block.
// Holds the tour geometry, the input item type and the slot access helper.
// No dependencies.
`default_nettype none

package pox_pkg;

    localparam int CITIES = 8;
    localparam int SLOT_W = 3;              // bits per city index
    localparam int TOUR_W = CITIES * SLOT_W;  // 24
    localparam int CNT_W  = $clog2(CITIES + 1); // holds 0..CITIES
    localparam int IN_W   = 2 * TOUR_W + 2 * SLOT_W; // packed input fields
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((TOUR_W + 7) / 8) * 8;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [TOUR_W-1:0] t_tour;
    typedef logic [CITIES-1:0] t_mask;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Packed with parent_first in the lowest bits, matching s_axis_tdata.
    typedef struct packed {
        t_slot cut_b;
        t_slot cut_a;
        t_tour parent_second;
        t_tour parent_first;
    } t_item;

    function automatic t_slot get_slot(t_tour tour, int unsigned idx);
        return tour[idx*SLOT_W +: SLOT_W];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pox_seg.sv
// Segment mask for the order crossover: which child slots are kept from
// the first parent. Depends on pox_pkg.
`default_nettype none

module pox_seg
    import pox_pkg::*;
(
    input  wire logic  i_two_point,
    input  wire t_slot i_cut_a,
    input  wire t_slot i_cut_b,
    output t_mask      o_seg
);

    t_slot lo;
    t_slot hi;
    t_cnt  pos;

    always_comb begin
        lo    = (i_cut_a < i_cut_b) ? i_cut_a : i_cut_b;
        hi    = (i_cut_a < i_cut_b) ? i_cut_b : i_cut_a;
        pos   = '0;
        o_seg = '0;
        // A 3-bit cut never exceeds the last slot, so no saturation is needed.
        for (int p = 0; p < CITIES; p++) begin
            pos = CNT_W'(p);
            if (i_two_point) begin
                o_seg[p] = (pos >= {1'b0, lo}) && (pos <= {1'b0, hi});
            end else begin
                o_seg[p] = pos < {1'b0, i_cut_a};
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pox_fill.sv
// Hole fill for the order crossover: places the second parent's new cities
// into the holes outside the kept segment, in order. Depends on pox_pkg.
`default_nettype none

module pox_fill
    import pox_pkg::*;
(
    input  wire t_mask i_seg,
    input  wire t_tour i_parent_first,
    input  wire t_tour i_parent_second,
    output t_tour      o_child,
    output logic       o_err
);

    t_slot c     [CITIES];
    t_cnt  rank  [CITIES];   // order of a new city among all new cities
    t_cnt  hrank [CITIES];   // order of a hole among all holes
    t_mask is_new;
    logic  inseg;
    logic  first;
    t_cnt  acc_n;
    t_cnt  acc_h;
    t_slot pick;

    always_comb begin
        is_new = '0;
        inseg  = 1'b0;
        first  = 1'b1;
        acc_n  = '0;
        acc_h  = '0;
        pick   = '0;
        o_child = '0;
        for (int i = 0; i < CITIES; i++) begin
            c[i]     = get_slot(i_parent_second, i);
            rank[i]  = '0;
            hrank[i] = '0;
        end

        // A city is new if it is outside the segment and its first occurrence.
        // A later repeat of a dropped city is dropped again, so repeats never
        // count.
        for (int i = 0; i < CITIES; i++) begin
            inseg = 1'b0;
            first = 1'b1;
            for (int j = 0; j < CITIES; j++) begin
                if (i_seg[j] && (get_slot(i_parent_first, j) == c[i])) begin
                    inseg = 1'b1;
                end
                if ((j < i) && (c[j] == c[i])) begin
                    first = 1'b0;
                end
            end
            is_new[i] = !inseg && first;
        end

        for (int i = 0; i < CITIES; i++) begin
            rank[i]  = acc_n;
            hrank[i] = acc_h;
            acc_n = acc_n + CNT_W'(is_new[i]);
            acc_h = acc_h + CNT_W'(!i_seg[i]);
        end

        // k-th hole takes the k-th new city; missing ones read as city 0
        for (int p = 0; p < CITIES; p++) begin
            pick = '0;
            for (int i = 0; i < CITIES; i++) begin
                if (is_new[i] && (rank[i] == hrank[p])) begin
                    pick = pick | c[i];
                end
            end
            o_child[p*SLOT_W +: SLOT_W] = i_seg[p] ? get_slot(i_parent_first, p) : pick;
        end

        o_err = acc_n != acc_h;
    end

endmodule

`default_nettype wire

FILE: rtl/permutation_order_crossover.sv
// Permutation order crossover, top level: input stage, crossover logic, result register.
// Takes one item per cycle unless m_axis_tready stalls the output.
// The combinational crossover sits between the input stage and the result register.
// Reset (i_rst_n low, synchronous) empties both stages and clears the mode to one-point.
// Depends on pox_pkg, pox_seg and pox_fill.
`default_nettype none

module permutation_order_crossover
    import pox_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // mode register: 0 one-point, 1 two-point
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_wdata,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [23:0] parent_first, [47:24] parent_second, [50:48] cut_a, [53:51] cut_b,
    // [55:54] unused
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [23:0] child_tour
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] fill_error
    output logic                        m_axis_tuser
);

    logic  r_mode;
    logic  r_s1_v;
    t_item r_s1_item;
    logic  r_out_v;
    t_tour r_out_child;
    logic  r_out_err;

    logic  out_adv;   // result register may load
    logic  s1_adv;    // input stage may load
    t_mask seg;
    t_tour n_child;
    logic  n_err;

    // Each stage moves when the one after it is empty or draining, so a new
    // item is taken every cycle while results flow out.
    assign out_adv       = !r_out_v || m_axis_tready;
    assign s1_adv        = !r_s1_v || out_adv;
    assign s_axis_tready = s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (s1_adv) begin
                r_s1_v <= s_axis_tvalid;
            end
            if (out_adv) begin
                r_out_v <= r_s1_v;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s1_adv && s_axis_tvalid) begin
            r_s1_item <= t_item'(s_axis_tdata[IN_W-1:0]);
        end
        if (out_adv && r_s1_v) begin
            r_out_child <= n_child;
            r_out_err   <= n_err;
        end
    end

    pox_seg u_seg (
        .i_two_point (r_mode),
        .i_cut_a     (r_s1_item.cut_a),
        .i_cut_b     (r_s1_item.cut_b),
        .o_seg       (seg)
    );

    pox_fill u_fill (
        .i_seg           (seg),
        .i_parent_first  (r_s1_item.parent_first),
        .i_parent_second (r_s1_item.parent_second),
        .o_child         (n_child),
        .o_err           (n_err)
    );

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_child);
    assign m_axis_tuser  = r_out_err;

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // A staged item reaches an empty result register in the next cycle.
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !r_out_v) |=> m_axis_tvalid)
        else $error("staged item did not advance");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
